// ===== design/pwcf_pkg.sv =====
// pwcf_pkg: shared types, codes and defaults for the PID block with command filter.
// Used by pwcf_cfg, pwcf_muldiv and pid_with_command_filter. No dependencies.
`default_nettype none

package pwcf_pkg;

    // Default datapath format: Q16.16
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_TAU    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_LIMIT = 3'd4;

    // Shared multiply/divide unit operation
    typedef enum logic {
        MD_MUL,
        MD_DIV
    } t_md_op;

    // Request to the shared unit
    typedef struct packed {
        logic   start;
        t_md_op op;
    } t_md_ctl;

    // Magnitude width of a dividend: big enough for a sum of two products
    // and for a difference shifted up by the fraction bits.
    function automatic int f_num_w(input int data_w, input int frac_w);
        int a;
        int b;
        a = 2 * data_w;
        b = data_w + frac_w + 1;
        return (a > b) ? a : b;
    endfunction

endpackage

`default_nettype wire

// ===== design/pwcf_cfg.sv =====
// pwcf_cfg: configuration register file (gains, filter time constant, command limit).
// Depends on pwcf_pkg for register indexes and defaults.
`default_nettype none

module pwcf_cfg #(
    parameter int DATA_WIDTH = pwcf_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = pwcf_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pwcf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [DATA_WIDTH-1:0]               i_cfg_data,
    output logic signed [DATA_WIDTH-1:0]        o_prop_gain,
    output logic signed [DATA_WIDTH-1:0]        o_deriv_gain,
    output logic signed [DATA_WIDTH-1:0]        o_integ_gain,
    output logic        [DATA_WIDTH-2:0]        o_filter_tau,
    output logic signed [DATA_WIDTH-1:0]        o_command_limit
);

    localparam int W = DATA_WIDTH;
    localparam int F = FRAC_BITS;
    // -1.0 in the data format
    localparam logic [W+F:0]  LIM_WIDE = {(W+F+1){1'b1}} << F;
    localparam logic [W-1:0]  LIM_RST  = LIM_WIDE[W-1:0];

    logic signed [W-1:0] r_prop_gain;
    logic signed [W-1:0] r_deriv_gain;
    logic signed [W-1:0] r_integ_gain;
    logic        [W-2:0] r_filter_tau;
    logic signed [W-1:0] r_command_limit;

    // Writes are always taken; unknown indexes are dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain     <= '0;
            r_deriv_gain    <= '0;
            r_integ_gain    <= '0;
            r_filter_tau    <= '0;
            r_command_limit <= LIM_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pwcf_pkg::CFG_PROP_GAIN:     r_prop_gain     <= i_cfg_data;
                pwcf_pkg::CFG_DERIV_GAIN:    r_deriv_gain    <= i_cfg_data;
                pwcf_pkg::CFG_INTEG_GAIN:    r_integ_gain    <= i_cfg_data;
                pwcf_pkg::CFG_FILTER_TAU:    r_filter_tau    <= i_cfg_data[W-2:0];
                pwcf_pkg::CFG_COMMAND_LIMIT: r_command_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_prop_gain     = r_prop_gain;
    assign o_deriv_gain    = r_deriv_gain;
    assign o_integ_gain    = r_integ_gain;
    assign o_filter_tau    = r_filter_tau;
    assign o_command_limit = r_command_limit;

endmodule

`default_nettype wire

// ===== design/pwcf_muldiv.sv =====
// pwcf_muldiv: shared bit-serial signed multiplier and truncating divider.
// One add/subtract step per cycle. Depends on pwcf_pkg (t_md_ctl, f_num_w).
`default_nettype none

module pwcf_muldiv #(
    parameter int DATA_WIDTH = pwcf_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = pwcf_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pwcf_pkg::t_md_ctl    i_ctl,
    input  logic signed [DATA_WIDTH:0] i_mul_a,
    input  logic signed [DATA_WIDTH:0] i_mul_b,
    input  logic signed [pwcf_pkg::f_num_w(DATA_WIDTH, FRAC_BITS):0] i_num,
    input  logic        [DATA_WIDTH-1:0] i_den,
    output logic                 o_done,
    output logic signed [pwcf_pkg::f_num_w(DATA_WIDTH, FRAC_BITS)+1:0] o_result
);

    localparam int W  = DATA_WIDTH;
    localparam int MW = W + 1;
    localparam int NW = pwcf_pkg::f_num_w(DATA_WIDTH, FRAC_BITS);
    localparam int RW = NW + 2;
    localparam int CW = $clog2(NW);

    logic                 r_busy;
    logic                 r_fin;
    logic                 r_done;
    pwcf_pkg::t_md_op     r_op;
    logic                 r_neg;
    logic [CW-1:0]        r_cnt;
    logic [W:0]           r_hi;
    logic [NW-1:0]        r_lo;
    logic [W:0]           r_opnd;
    logic signed [RW-1:0] r_result;

    logic [W:0]           w_mag_a;
    logic [W:0]           w_mag_b;
    logic [NW:0]          w_num_neg;
    logic [NW-1:0]        w_mag_n;
    logic [W:0]           w_shift;
    logic [W+1:0]         w_add_a;
    logic [W+1:0]         w_add_b;
    logic                 w_cin;
    logic [W+1:0]         w_sum;
    logic [RW-1:0]        w_mag_res;

    // Operand magnitudes at start; the sign is put back at the end
    assign w_mag_a   = i_mul_a[W] ? (~i_mul_a + (W+1)'(1)) : i_mul_a;
    assign w_mag_b   = i_mul_b[W] ? (~i_mul_b + (W+1)'(1)) : i_mul_b;
    assign w_num_neg = ~i_num + (NW+1)'(1);
    assign w_mag_n   = i_num[NW] ? w_num_neg[NW-1:0] : i_num[NW-1:0];

    // Shared adder: add multiplicand (multiply) or subtract divisor (divide)
    assign w_shift = {r_hi[W-1:0], r_lo[NW-1]};
    always_comb begin
        if (r_op == pwcf_pkg::MD_DIV) begin
            w_add_a = {1'b0, w_shift};
            w_add_b = ~{1'b0, r_opnd};
            w_cin   = 1'b1;
        end else begin
            w_add_a = {1'b0, r_hi};
            w_add_b = r_lo[0] ? {1'b0, r_opnd} : '0;
            w_cin   = 1'b0;
        end
    end
    assign w_sum = w_add_a + w_add_b + (W+2)'(w_cin);

    // Unsigned result: product sits in hi plus the top of lo, quotient in lo
    assign w_mag_res = (r_op == pwcf_pkg::MD_MUL) ? RW'({r_hi, r_lo[NW-1 -: MW]})
                                                  : RW'(r_lo);

    // Sequencer: start, one step a cycle, finish
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_op <= i_ctl.op;
            r_hi <= '0;
            if (i_ctl.op == pwcf_pkg::MD_MUL) begin
                r_opnd <= w_mag_a;
                r_lo   <= NW'(w_mag_b);
                r_neg  <= i_mul_a[W] ^ i_mul_b[W];
                r_cnt  <= CW'(MW - 1);
            end else begin
                r_opnd <= {1'b0, i_den};
                r_lo   <= w_mag_n;
                r_neg  <= i_num[NW];
                r_cnt  <= CW'(NW - 1);
            end
        end else if (r_busy) begin
            r_cnt <= r_cnt - CW'(1);
            if (r_op == pwcf_pkg::MD_DIV) begin
                // restoring step: keep the difference when it is not negative
                r_hi <= w_sum[W+1] ? w_shift : w_sum[W:0];
                r_lo <= {r_lo[NW-2:0], ~w_sum[W+1]};
            end else begin
                // shift-add step, multiplier bits leave at the bottom
                r_hi <= w_sum[W+1:1];
                r_lo <= {w_sum[0], r_lo[NW-1:1]};
            end
        end else if (r_fin) begin
            r_result <= r_neg ? (~w_mag_res + RW'(1)) : w_mag_res;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

`ifndef SYNTHESIS
    // A new request never lands on an operation in flight
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |-> (!r_busy && !r_fin))
        else $error("muldiv request while busy");

    // Completion always follows the finish cycle
    a_done_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_fin))
        else $error("muldiv done without finish");
`endif

endmodule

`default_nettype wire

// ===== design/pid_with_command_filter.sv =====
// pid_with_command_filter: top level; clamp, command filter, PID terms, sequencer.
// Depends on pwcf_pkg, pwcf_cfg and pwcf_muldiv.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------
//  in      | to block  | i_in_valid / o_in_stall    | setpoint, measured, rate, dt
//  out     | from blk  | o_out_valid / i_out_stall  | drive
//  cfg     | to block  | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One request at a time through a shared bit-serial multiply/divide unit.
// Default data format is Q16.16; the dividend width is NW = max(2W, W+F+1),
// 64 bits at Q16.16. With time step and time constant both zero the two divides
// and two filter products are skipped. Reset (synchronous, active low) clears
// filter state, integrator, gains and time constant, and sets the command limit
// to -1.0. A result waiting on a stalled output does not block the next request.
`default_nettype none

module pid_with_command_filter #(
    parameter int DATA_WIDTH = pwcf_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = pwcf_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input requests
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic signed [DATA_WIDTH-1:0]     i_setpoint,
    input  logic signed [DATA_WIDTH-1:0]     i_measured,
    input  logic signed [DATA_WIDTH-1:0]     i_measured_rate,
    input  logic        [DATA_WIDTH-2:0]     i_time_step,
    // results
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic signed [DATA_WIDTH-1:0]     o_drive,
    // configuration
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [pwcf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [DATA_WIDTH-1:0]            i_cfg_data
);

    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int NW = pwcf_pkg::f_num_w(DATA_WIDTH, FRAC_BITS);
    localparam int RW = NW + 2;
    localparam int PW = 2 * W + 2;
    localparam int AW = PW + 2;
    localparam int SW = NW + 5;

    // Sequencer states
    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_CHK     = 5'd1;
    localparam logic [4:0] S_RATE_GO = 5'd2;
    localparam logic [4:0] S_RATE_W  = 5'd3;
    localparam logic [4:0] S_FA_GO   = 5'd4;
    localparam logic [4:0] S_FA_W    = 5'd5;
    localparam logic [4:0] S_FB_GO   = 5'd6;
    localparam logic [4:0] S_FB_W    = 5'd7;
    localparam logic [4:0] S_FC_GO   = 5'd8;
    localparam logic [4:0] S_FC_W    = 5'd9;
    localparam logic [4:0] S_PD      = 5'd10;
    localparam logic [4:0] S_I_GO    = 5'd11;
    localparam logic [4:0] S_I_W     = 5'd12;
    localparam logic [4:0] S_KP_GO   = 5'd13;
    localparam logic [4:0] S_KP_W    = 5'd14;
    localparam logic [4:0] S_KD_GO   = 5'd15;
    localparam logic [4:0] S_KD_W    = 5'd16;
    localparam logic [4:0] S_KI_GO   = 5'd17;
    localparam logic [4:0] S_KI_W    = 5'd18;
    localparam logic [4:0] S_OUT     = 5'd19;

    logic [4:0]           r_state;
    logic [4:0]           n_state;

    // request payload
    logic signed [W-1:0]  r_cmd;
    logic signed [W-1:0]  r_x;
    logic signed [W-1:0]  r_dx;
    logic        [W-2:0]  r_dt;
    logic        [W-1:0]  r_den;
    // persistent state
    logic signed [W-1:0]  r_fc;
    logic signed [W-1:0]  r_rate;
    logic signed [W-1:0]  r_ei;
    // working values
    logic signed [NW:0]   r_num;
    logic signed [PW-1:0] r_tmp;
    logic signed [W:0]    r_p;
    logic signed [W:0]    r_d;
    logic signed [AW-1:0] r_acc;
    logic                 r_out_valid;
    logic signed [W-1:0]  r_drive;

    logic signed [W-1:0]  w_prop_gain;
    logic signed [W-1:0]  w_deriv_gain;
    logic signed [W-1:0]  w_integ_gain;
    logic        [W-2:0]  w_filter_tau;
    logic signed [W-1:0]  w_command_limit;

    logic                 w_in_acc;
    logic                 w_out_free;
    logic                 w_lim_pos;
    logic signed [W-1:0]  w_neg_lim;
    logic signed [W-1:0]  w_cmd;
    logic signed [W:0]    w_rdiff;
    logic signed [NW:0]   w_rnum;
    pwcf_pkg::t_md_ctl    w_md_ctl;
    logic signed [W:0]    w_mul_a;
    logic signed [W:0]    w_mul_b;
    logic                 w_md_done;
    logic signed [RW-1:0] w_md_result;
    logic signed [PW-1:0] w_prod;
    logic signed [PW-1:0] w_prod_sh;
    logic signed [PW-1:0] w_fsum;
    logic signed [PW:0]   w_isum;

    // Clamp a wide signed value to the data range
    function automatic logic signed [W-1:0] f_sat(input logic signed [SW-1:0] v);
        logic [SW-W:0] hi_bits;
        hi_bits = v[SW-1:W-1];
        if ((&hi_bits) || !(|hi_bits)) begin
            return v[W-1:0];
        end
        return {v[SW-1], {(W-1){~v[SW-1]}}};
    endfunction

    pwcf_cfg #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_prop_gain     (w_prop_gain),
        .o_deriv_gain    (w_deriv_gain),
        .o_integ_gain    (w_integ_gain),
        .o_filter_tau    (w_filter_tau),
        .o_command_limit (w_command_limit)
    );

    pwcf_muldiv #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_muldiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_md_ctl),
        .i_mul_a  (w_mul_a),
        .i_mul_b  (w_mul_b),
        .i_num    (r_num),
        .i_den    (r_den),
        .o_done   (w_md_done),
        .o_result (w_md_result)
    );

    // Handshakes
    assign w_in_acc   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // Command clamp, active only for a positive limit
    assign w_lim_pos = !w_command_limit[W-1] && (|w_command_limit);
    assign w_neg_lim = -w_command_limit;
    always_comb begin
        w_cmd = i_setpoint;
        if (w_lim_pos) begin
            if (i_setpoint > w_command_limit) begin
                w_cmd = w_command_limit;
            end else if (i_setpoint < w_neg_lim) begin
                w_cmd = w_neg_lim;
            end
        end
    end

    // Rate dividend: (command - old filter output) scaled by the fraction bits
    assign w_rdiff = (W+1)'(r_cmd) - (W+1)'(r_fc);
    assign w_rnum  = (NW+1)'(w_rdiff) <<< F;

    // Products from the shared unit, floored term and filter numerator
    assign w_prod    = w_md_result[PW-1:0];
    assign w_prod_sh = w_prod >>> F;
    assign w_fsum    = r_tmp + w_prod;
    assign w_isum    = (PW+1)'(r_ei) + (PW+1)'(w_prod_sh);

    // Shared unit request decode
    always_comb begin
        w_md_ctl.start = 1'b0;
        w_md_ctl.op    = pwcf_pkg::MD_MUL;
        unique case (r_state) inside
            S_RATE_GO, S_FC_GO: begin
                w_md_ctl.start = 1'b1;
                w_md_ctl.op    = pwcf_pkg::MD_DIV;
            end
            S_FA_GO, S_FB_GO, S_I_GO, S_KP_GO, S_KD_GO, S_KI_GO: begin
                w_md_ctl.start = 1'b1;
            end
            default: ;
        endcase
    end

    // Multiplier operand select
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            S_FA_GO: begin
                w_mul_a = (W+1)'(r_dt);
                w_mul_b = (W+1)'(r_cmd);
            end
            S_FB_GO: begin
                w_mul_a = (W+1)'(w_filter_tau);
                w_mul_b = (W+1)'(r_fc);
            end
            S_I_GO: begin
                w_mul_a = (W+1)'(r_dt);
                w_mul_b = r_p;
            end
            S_KP_GO: begin
                w_mul_a = (W+1)'(w_prop_gain);
                w_mul_b = r_p;
            end
            S_KD_GO: begin
                w_mul_a = (W+1)'(w_deriv_gain);
                w_mul_b = r_d;
            end
            S_KI_GO: begin
                w_mul_a = (W+1)'(w_integ_gain);
                w_mul_b = (W+1)'(r_ei);
            end
            default: ;
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (w_in_acc) n_state = S_CHK;
            S_CHK:     n_state = (r_den == '0) ? S_PD : S_RATE_GO;
            S_RATE_GO: n_state = S_RATE_W;
            S_RATE_W:  if (w_md_done) n_state = S_FA_GO;
            S_FA_GO:   n_state = S_FA_W;
            S_FA_W:    if (w_md_done) n_state = S_FB_GO;
            S_FB_GO:   n_state = S_FB_W;
            S_FB_W:    if (w_md_done) n_state = S_FC_GO;
            S_FC_GO:   n_state = S_FC_W;
            S_FC_W:    if (w_md_done) n_state = S_PD;
            S_PD:      n_state = S_I_GO;
            S_I_GO:    n_state = S_I_W;
            S_I_W:     if (w_md_done) n_state = S_KP_GO;
            S_KP_GO:   n_state = S_KP_W;
            S_KP_W:    if (w_md_done) n_state = S_KD_GO;
            S_KD_GO:   n_state = S_KD_W;
            S_KD_W:    if (w_md_done) n_state = S_KI_GO;
            S_KI_GO:   n_state = S_KI_W;
            S_KI_W:    if (w_md_done) n_state = S_OUT;
            S_OUT:     if (w_out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Control and persistent state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_fc        <= '0;
            r_rate      <= '0;
            r_ei        <= '0;
        end else begin
            r_state <= n_state;
            // a new result replaces one leaving this cycle
            if ((r_state == S_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_md_done) begin
                case (r_state)
                    S_RATE_W: r_rate <= f_sat(SW'(w_md_result));
                    S_FC_W:   r_fc   <= f_sat(SW'(w_md_result));
                    S_I_W:    r_ei   <= f_sat(SW'(w_isum));
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state) inside
            S_IDLE: begin
                if (w_in_acc) begin
                    r_cmd <= w_cmd;
                    r_x   <= i_measured;
                    r_dx  <= i_measured_rate;
                    r_dt  <= i_time_step;
                    r_den <= W'(i_time_step) + W'(w_filter_tau);
                end
            end
            S_CHK: r_num <= w_rnum;
            S_FA_W: begin
                if (w_md_done) r_tmp <= w_prod;
            end
            S_FB_W: begin
                // filter numerator: dt*cmd + tau*old, fits the dividend
                if (w_md_done) r_num <= (NW+1)'(w_fsum);
            end
            S_PD: begin
                r_p <= (W+1)'(r_fc) - (W+1)'(r_x);
                r_d <= (W+1)'(r_rate) - (W+1)'(r_dx);
            end
            S_KP_W: begin
                if (w_md_done) r_acc <= AW'(w_prod_sh);
            end
            S_KD_W, S_KI_W: begin
                if (w_md_done) r_acc <= r_acc + AW'(w_prod_sh);
            end
            S_OUT: begin
                if (w_out_free) r_drive <= f_sat(SW'(r_acc));
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_drive     = r_drive;

`ifndef SYNTHESIS
    // A result appears only out of the output step
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_OUT))
        else $error("result without sequencer output step");

    // An accepted request always starts with the divisor check
    a_accept_chk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_CHK))
        else $error("accepted request did not start");
`endif

endmodule

`default_nettype wire
